FILE: src/stkl_pkg.sv
// shared types and codes for the sorted top-k list
package stkl_pkg;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_GET    = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
      logic [3:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_cmd_type;

endpackage

FILE: src/stkl_ctrl.sv
// controller: accepts a request, runs the execute state, strobes the response
module stkl_ctrl
   import stkl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output ctl_cmd_type cmd,
   output logic        rsp_valid
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.execute;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/stkl_dpath.sv
// datapath: row of compare-and-shift cells, entry count and response register
module stkl_dpath
   import stkl_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   input  req_type     req_data,
   output rsp_type     rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 4) ? CW : 4;

   req_type                       req_ff;
   logic signed [VALUE_WIDTH-1:0] entry_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] entry_in [CAPACITY];
   logic [CW-1:0]                 count_ff, count_in;
   rsp_type                       rsp_ff, rsp_in;

   logic signed [VALUE_WIDTH-1:0] new_val;
   logic [CAPACITY-1:0]           take;
   logic [CAPACITY-1:0]           shift_up;
   logic                          full;
   logic                          reject;
   logic                          in_range;
   logic [IW-1:0]                 rd_addr;
   logic signed [VALUE_WIDTH-1:0] rd_val;
   logic                          do_add;
   logic                          do_remove;

   assign new_val  = VALUE_WIDTH'(req_ff.value);
   assign full     = (count_ff == CW'(CAPACITY));
   assign reject   = full && !take[CAPACITY-1];
   assign in_range = (XW'(req_ff.index) < XW'(count_ff));
   assign rd_addr  = IW'(req_ff.index);
   assign rd_val   = entry_ff[rd_addr];

   assign do_add    = (req_ff.mode == MODE_ADD) && !reject;
   assign do_remove = (req_ff.mode == MODE_REMOVE) && in_range;

   // each cell: beyond the count, or holding a value below the new one
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign take[i]     = (CW'(i) >= count_ff) || (entry_ff[i] < new_val);
      assign shift_up[i] = (XW'(i) >= XW'(req_ff.index));

      always_comb begin
         entry_in[i] = entry_ff[i];
         if (do_add && take[i]) begin
            if (i == 0) begin
               entry_in[i] = new_val;
            end else begin
               entry_in[i] = take[(i > 0) ? i - 1 : 0] ? entry_ff[(i > 0) ? i - 1 : 0]
                                                       : new_val;
            end
         end else if (do_remove && shift_up[i] && (i < CAPACITY - 1)) begin
            entry_in[i] = entry_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in            = count_ff;
      rsp_in.result_value = '0;
      rsp_in.status       = STATUS_OK;
      unique case (req_ff.mode) inside
         MODE_ADD: begin
            if (reject) begin
               rsp_in.status = STATUS_REJECT;
            end else if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end
         MODE_REMOVE, MODE_GET: begin
            if (!in_range) begin
               rsp_in.status = STATUS_RANGE;
            end else begin
               rsp_in.result_value = 32'($unsigned(rd_val));
               if (req_ff.mode == MODE_REMOVE) count_in = count_ff - CW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         for (int k = 0; k < CAPACITY; k++) entry_ff[k] <= entry_in[k];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: src/sorted_top_k_list_top.sv
// top level of the sorted top-k list
//
// keeps up to CAPACITY signed values in descending order (index 0 is the
// largest). one request carries mode, value and index:
//   add    inserts value at its sorted place, after any equal values; on a
//          full list a value no greater than the smallest entry is rejected,
//          otherwise the smallest entry is dropped
//   remove returns the entry at index and closes the gap
//   get    returns the entry at index
// an index at or beyond the entry count gives an out-of-range status.
//
// request channel: a transfer happens on the clock edge with start high and
// busy low. busy is high for the one execute cycle that follows.
// response channel: rsp_valid is high for exactly one cycle, the cycle after
// the execute cycle, with rsp_data; the receiver cannot stall the response.
// a new request is accepted only after the execute cycle of the last one;
// all cells compare and shift in the execute cycle.
// reset clears the entry count and the controller; entry storage is not reset.
module sorted_top_k_list_top
   import stkl_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;

   // request capture and execute sequencing
   stkl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   // sorted cell row and response register
   stkl_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // response strobe only lands once the execute cycle is over
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // an accepted request is executed on the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request not executed");

   // every execute cycle yields exactly one response
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("execute cycle without response");

   // no response without a preceding execute cycle
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without execute");

endmodule

FILE: tb/sv/sorted_top_k_list_top_tb.sv
// self-checking testbench for the sorted top-k list
module sorted_top_k_list_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stkl_pkg::*;

   localparam int LIST_DEPTH   = 16;
   localparam int NUM_RANDOM   = 1950;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int GAP_PERCENT  = 11;

   // behavioral copy of the list, the responses it predicts and the mismatch count
   class top_k_scoreboard;
      logic signed [31:0] list_vals [LIST_DEPTH];
      int unsigned        list_len;
      rsp_type            expected_rsps [$];
      int                 mismatches;

      function new();
         list_len   = 0;
         mismatches = 0;
      endfunction

      // applies one request to the list and returns the response it should give
      function rsp_type apply_list_op(req_type r);
         rsp_type            e;
         logic signed [31:0] v;
         int                 pos;
         e = '0;
         v = r.value;
         case (r.mode)
            MODE_ADD: begin
               // full list: only a value above the smallest entry gets in
               if (list_len >= LIST_DEPTH && v <= list_vals[LIST_DEPTH-1]) begin
                  e.status = STATUS_REJECT;
               end else begin
                  if (list_len >= LIST_DEPTH) begin
                     pos = LIST_DEPTH - 1;
                  end else begin
                     pos = list_len;
                     list_len++;
                  end
                  // strict compare keeps a new value behind equal ones
                  while (pos > 0 && v > list_vals[pos-1]) begin
                     list_vals[pos] = list_vals[pos-1];
                     pos--;
                  end
                  list_vals[pos] = v;
               end
            end
            MODE_REMOVE, MODE_GET: begin
               if (r.index >= list_len) begin
                  e.status = STATUS_RANGE;
               end else begin
                  e.result_value = list_vals[r.index];
                  if (r.mode == MODE_REMOVE) begin
                     for (pos = r.index; pos + 1 < list_len; pos++)
                        list_vals[pos] = list_vals[pos+1];
                     list_len--;
                  end
               end
            end
            default: ;
         endcase
         e.entry_count = 5'(list_len);
         return e;
      endfunction

      function void note_request(req_type r);
         expected_rsps.push_back(apply_list_op(r));
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         e = expected_rsps.pop_front();
         if (got.result_value !== e.result_value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      got.result_value, e.result_value));
         if (got.status !== e.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
         if (got.entry_count !== e.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, e.entry_count));
      endtask
   endclass

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   top_k_scoreboard board;
   int              idle_cycles = 0;

   always #5 clock = ~clock;

   sorted_top_k_list_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // response monitor: values seen at the edge are the ones of the cycle it ends
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_response(rsp_data);
   end

   // watchdog: any transfer on either side restarts the count
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic req_type make_req(logic [1:0] mode, logic signed [31:0] value,
                                        logic [3:0] index);
      req_type r;
      r.mode  = mode;
      r.value = value;
      r.index = index;
      return r;
   endfunction

   // one request transfer: optional idle cycles, then hold start until busy is low
   // at an edge; start stays high straight into the next request when no gap follows
   task automatic send_request(req_type r, bit allow_gaps);
      while (allow_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
   endtask

   // value mix: extremes, a narrow band that makes ties, and the full range
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7fffffff;
               1:       return 32'sh80000000;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return int'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // operation mix leans by phase so the list fills, drains and sits full
   function automatic logic [1:0] pick_mode(int phase);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return MODE_NOP;
      case (phase)
         0:       return (roll < 75) ? MODE_ADD : (roll < 85) ? MODE_REMOVE : MODE_GET;
         1:       return (roll < 25) ? MODE_ADD : (roll < 75) ? MODE_REMOVE : MODE_GET;
         default: return (roll < 52) ? MODE_ADD : (roll < 76) ? MODE_REMOVE : MODE_GET;
      endcase
   endfunction

   initial begin : stimulus
      int         k;
      bit         gaps;
      logic [3:0] idx;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, unused mode, extremes, ties, range errors
      send_request(make_req(MODE_GET, 32'sd0, 4'd0), 1'b1);
      send_request(make_req(MODE_REMOVE, 32'sd0, 4'd0), 1'b1);
      send_request(make_req(MODE_NOP, 32'shffffffff, 4'd15), 1'b1);
      send_request(make_req(MODE_ADD, 32'sh7fffffff, 4'd15), 1'b1);
      send_request(make_req(MODE_ADD, 32'sh80000000, 4'd0), 1'b1);
      send_request(make_req(MODE_ADD, 32'sd0, 4'd0), 1'b1);
      send_request(make_req(MODE_ADD, 32'sd0, 4'd0), 1'b1);
      send_request(make_req(MODE_GET, 32'sd0, 4'd0), 1'b1);
      send_request(make_req(MODE_GET, 32'sd0, 4'd3), 1'b1);
      send_request(make_req(MODE_GET, 32'sd0, 4'd4), 1'b1);
      send_request(make_req(MODE_REMOVE, 32'sd0, 4'd1), 1'b1);
      // fill to capacity, then the full-list cases
      for (k = 0; k < LIST_DEPTH - 3; k++)
         send_request(make_req(MODE_ADD, k * 1000 - 6000, 4'd0), 1'b0);
      send_request(make_req(MODE_GET, 32'sd0, 4'd15), 1'b1);
      send_request(make_req(MODE_ADD, 32'sh80000000, 4'd0), 1'b1);
      send_request(make_req(MODE_ADD, -32'sd5, 4'd0), 1'b1);
      send_request(make_req(MODE_REMOVE, 32'sd0, 4'd15), 1'b1);
      send_request(make_req(MODE_REMOVE, 32'sd0, 4'd0), 1'b1);

      // random: phases of 150 requests, a no-gap stretch in the middle
      for (k = 0; k < NUM_RANDOM; k++) begin
         gaps = !(k >= 700 && k < 1100);
         if (board.list_len > 0 && $urandom_range(0, 9) < 8)
            idx = 4'($urandom_range(0, board.list_len - 1));
         else
            idx = 4'($urandom_range(0, 15));
         send_request(make_req(pick_mode((k / 150) % 3), pick_value(), idx), gaps);
      end
      start <= 1'b0;

      // wait out the outstanding responses plus a little pipeline slack
      while (board.expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
src/stkl_pkg.sv
src/stkl_ctrl.sv
src/stkl_dpath.sv
src/sorted_top_k_list_top.sv
tb/sv/sorted_top_k_list_top_tb.sv
